FILE: hw/rtl/d96i_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package d96i_pkg;

    localparam int MANT_W    = 96;
    localparam int CELL_W    = 8;
    localparam int NUM_CELLS = MANT_W / CELL_W;
    localparam int REM_W     = 4;
    localparam int CUR_W     = REM_W + CELL_W;

    // floor(x / 10) == (x * 6554) >> 16 for every x below 2560.
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 16;
    localparam logic [RECIP_W-1:0] RECIP = 13'd6554;
    localparam logic [CUR_W-1:0]   RADIX = 12'd10;

    // After 29 divisions any 96-bit mantissa is zero.
    localparam int DIV_W = 5;
    localparam logic [DIV_W-1:0] MAX_DIV = 5'd29;

    localparam logic [31:0] INT_LIMIT = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

    // What one cell hands to the next lower cell.
    typedef struct packed {
        logic             en;
        logic [REM_W-1:0] rem;
    } link_t;

endpackage

`default_nettype wire

FILE: hw/rtl/d96i_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module d96i_cell (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       load,
    input  wire logic [d96i_pkg::CELL_W-1:0] load_byte,
    input  wire d96i_pkg::link_t             link_in,
    output d96i_pkg::link_t                  link_out,
    output logic [d96i_pkg::CELL_W-1:0]      digit
);
    import d96i_pkg::*;

    logic [CELL_W-1:0]          byte_reg;
    link_t                      link_reg;
    logic [CUR_W-1:0]           cur;
    logic [CUR_W+RECIP_W-1:0]   prod;
    logic [CELL_W-1:0]          quot;
    logic [CUR_W-1:0]           back;
    logic [REM_W-1:0]           rem;

    // The incoming remainder sits above this cell's byte.
    assign cur  = {link_in.rem, byte_reg};
    assign prod = {{RECIP_W{1'b0}}, cur} * {{CUR_W{1'b0}}, RECIP};
    assign quot = prod[RECIP_SHIFT +: CELL_W];
    assign back = cur - ({{REM_W{1'b0}}, quot} * RADIX);
    assign rem  = back[REM_W-1:0];

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= load_byte;
        end else if (link_in.en) begin
            byte_reg <= quot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_reg <= '0;
        end else if (load) begin
            link_reg <= '0;
        end else begin
            link_reg.en  <= link_in.en;
            link_reg.rem <= link_in.en ? rem : '0;
        end
    end

    assign link_out = link_reg;
    assign digit    = byte_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/decimal96_to_int32.sv
// Truncating conversion of a 96-bit decimal to a signed 32-bit integer.
// Input channel (s_): one word carries the three mantissa words and the scale
// in s_tdata and the sign flag in s_tuser. Result channel (m_): the signed
// value in m_tdata and the range error flag in m_tuser; value is 0 on error.
// The mantissa sits in a row of twelve byte cells. Each division by ten runs
// down the row as a wavefront, one cell per cycle, handing the remainder to
// the next lower cell; the top cell starts the next division in the cycle
// after, until N = min(scale, 29) divisions have started.
// s_tready is high only while the row is free, so a new word is taken only
// after the previous result has left the row.
// The result waits in an output register, so a new word is accepted while
// a finished result is still held. If the receiver stalls, the next result
// waits in the row until the output register is free.
// Reset (aresetn low, synchronous) stops any division in the row and clears
// the output valid flag; it returns the state to idle, so s_tready is high.
`timescale 1ns / 1ps
`default_nettype none

module decimal96_to_int32 (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // mantissa_low[31:0], mantissa_mid[63:32], mantissa_high[95:64], scale[103:96]
    input  wire logic [103:0]        s_tdata,
    // negative[0]
    input  wire logic                s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // value[31:0]
    output logic signed [31:0]       m_tdata,
    // error[0]
    output logic                     m_tuser
);
    import d96i_pkg::*;

    localparam int CNT_W = 6;
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;
    localparam logic [CNT_W-1:0] DRAIN = CNT_W'(NUM_CELLS - 1);

    logic                state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [DIV_W-1:0]    ndiv_reg, ndiv_next;
    logic                neg_reg, neg_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [31:0]         m_tdata_reg, m_tdata_next;
    logic                m_tuser_reg, m_tuser_next;

    logic                accept;
    logic                load;
    logic [CNT_W-1:0]    last;
    logic                finish;
    logic                out_free;
    logic [MANT_W-1:0]   mag;
    logic [7:0]          scale_in;
    logic                high_nz;
    logic [31:0]         limit;
    logic                err;

    link_t               link [NUM_CELLS];
    link_t               link_tail;
    logic [CELL_W-1:0]   digit [NUM_CELLS];

    assign scale_in = s_tdata[MANT_W +: 8];
    assign accept   = s_tvalid && s_tready;
    assign load     = accept;
    assign last     = {1'b0, ndiv_reg} + DRAIN;
    assign finish   = (state_reg == ST_RUN) && (cnt_reg == last);
    assign out_free = !m_tvalid_reg || m_tready;

    // The top cell starts one division per cycle while any remain.
    assign link[NUM_CELLS-1].en  = (state_reg == ST_RUN) && (cnt_reg < {1'b0, ndiv_reg});
    assign link[NUM_CELLS-1].rem = '0;

    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        if (i == 0) begin : g_tail
            d96i_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .load      (load),
                .load_byte (s_tdata[i*CELL_W +: CELL_W]),
                .link_in   (link[i]),
                .link_out  (link_tail),
                .digit     (digit[i])
            );
        end else begin : g_body
            d96i_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .load      (load),
                .load_byte (s_tdata[i*CELL_W +: CELL_W]),
                .link_in   (link[i]),
                .link_out  (link[i-1]),
                .digit     (digit[i])
            );
        end
        assign mag[i*CELL_W +: CELL_W] = digit[i];
    end

    assign high_nz = |mag[MANT_W-1:32];
    assign limit   = neg_reg ? NEG_LIMIT : INT_LIMIT;
    assign err     = high_nz || (mag[31:0] > limit);

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        ndiv_next     = ndiv_reg;
        neg_next      = neg_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_RUN;
                    cnt_next   = '0;
                    ndiv_next  = (scale_in > {3'b000, MAX_DIV}) ? MAX_DIV
                                                                : scale_in[DIV_W-1:0];
                    neg_next   = s_tuser;
                end
            end
            ST_RUN: begin
                if (finish) begin
                    if (out_free) begin
                        state_next    = ST_IDLE;
                        m_tvalid_next = 1'b1;
                        m_tuser_next  = err;
                        if (err) begin
                            m_tdata_next = '0;
                        end else if (neg_reg) begin
                            m_tdata_next = 32'd0 - mag[31:0];
                        end else begin
                            m_tdata_next = mag[31:0];
                        end
                    end
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ndiv_reg    <= ndiv_next;
        neg_reg     <= neg_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // A remainder leaving the bottom cell is always a decimal digit.
    a_rem_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        link_tail.en |-> (link_tail.rem < 4'd10))
        else $error("remainder out of digit range");

    // Every division has passed the bottom cell when the result is taken.
    a_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        finish |-> !link[0].en)
        else $error("division still in flight at finish");

    // The counter never runs past the end of the wavefronts.
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (cnt_reg <= last))
        else $error("cycle counter past end");

    // An error result carries a zero value.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == 32'sd0))
        else $error("error result with nonzero value");

endmodule

`default_nettype wire
